@@ rtl/mwm_pkg.sv @@
`default_nettype none
package mwm_pkg;

	localparam int HASH_W     = 64;
	localparam int PORT_LANES = 4;
	localparam int WIN_REG_W  = 7;
	localparam int LANE_REG_W = 3;
	localparam int CFG_DATA_W = 7;

	typedef logic [HASH_W-1:0] hash_t;

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_WINDOW_KMERS = 1'b0,
		REG_LANES_IN_USE = 1'b1
	} cfg_reg_t;

endpackage
`default_nettype wire

@@ rtl/minimizer_window_min_top.sv @@
`default_nettype none
// sliding-window minimum of k-mer hash tuples
// input stream s_*: one k-mer per request, tdata holds four 64-bit hash lanes,
// tuser flags the first k-mer of a sequence (clears the window)
// output stream m_*: one result per k-mer once a full window of the current
// sequence is held, tdata holds the four 64-bit lane minimums, unused lanes zero
// configuration: cfg_we/cfg_addr/cfg_data, index 0 window_kmers, 1 lanes_in_use;
// the user must have it written only while the block is idle, the block does not enforce this
// a row of WINDOW_MAX cells keeps the minimum over the newest 1..WINDOW_MAX items;
// each accepted k-mer updates every cell at once and the result is the new k-mer
// against the cell at depth window_kmers-1, so one k-mer is taken every cycle
// unless the output stalls; the result is loaded into the output register on acceptance
// a stalled receiver holds the output register; s_tready stays high as long as
// the register is empty or being emptied in the same cycle
// reset clears the k-mer count, the output valid and the registers to 1;
// the cells need no clearing since only cells filled within the sequence are read
module minimizer_window_min_top #(
	parameter int WINDOW_MAX = 64,
	parameter int LANES      = 4
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output      logic                                s_tready,
	input  wire logic [4*mwm_pkg::HASH_W-1:0]        s_tdata,  // hash_lane_0..hash_lane_3
	input  wire logic                                s_tuser,  // start_of_sequence
	output      logic                                m_tvalid,
	input  wire logic                                m_tready,
	output      logic [4*mwm_pkg::HASH_W-1:0]        m_tdata,  // min_lane_0..min_lane_3
	input  wire logic                                cfg_we,
	input  wire logic                                cfg_addr,
	input  wire logic [mwm_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import mwm_pkg::*;

	localparam int LIM = (LANES < PORT_LANES) ? LANES : PORT_LANES;
	localparam int CW  = $clog2(WINDOW_MAX + 1);
	localparam int IW  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

	logic [WIN_REG_W-1:0]  win_q;
	logic [LANE_REG_W-1:0] lanes_q;
	logic [CW-1:0]         seen_q;
	logic [CW-1:0]         seen_next;
	logic [CW-1:0]         seen_base;
	logic [CW-1:0]         w_eff;
	logic [CW-1:0]         w_m2;
	logic [IW-1:0]         w_idx;
	logic [LANE_REG_W-1:0] lanes_eff;
	logic                  accept;
	logic                  emit;
	logic                  out_valid_q;

	hash_t [LIM-1:0]        hash_in;
	hash_t [LIM-1:0]        sel_min;
	hash_t [LIM-1:0]        win_min;
	hash_t [LIM-1:0]        cell_min [WINDOW_MAX];
	hash_t [PORT_LANES-1:0] out_q;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;

	for (genvar j = 0; j < LIM; j++) begin : g_in
		assign hash_in[j] = s_tdata[HASH_W*j +: HASH_W];
	end

	for (genvar j = 0; j < PORT_LANES; j++) begin : g_out
		assign m_tdata[HASH_W*j +: HASH_W] = out_q[j];
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= WIN_REG_W'(1);
			lanes_q <= LANE_REG_W'(1);
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_WINDOW_KMERS: win_q   <= cfg_data[WIN_REG_W-1:0];
				REG_LANES_IN_USE: lanes_q <= cfg_data[LANE_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp registers to the supported range
	always_comb begin
		if (win_q == '0) begin
			w_eff = CW'(1);
		end else if (int'(win_q) > WINDOW_MAX) begin
			w_eff = CW'(WINDOW_MAX);
		end else begin
			w_eff = CW'(win_q);
		end
		if (lanes_q == '0) begin
			lanes_eff = LANE_REG_W'(1);
		end else if (int'(lanes_q) > LIM) begin
			lanes_eff = LANE_REG_W'(LIM);
		end else begin
			lanes_eff = lanes_q;
		end
	end

	// k-mer count of the current sequence, saturating
	always_comb begin
		seen_base = s_tuser ? '0 : seen_q;
		if (int'(seen_base) < WINDOW_MAX) begin
			seen_next = seen_base + CW'(1);
		end else begin
			seen_next = seen_base;
		end
		emit = (seen_next >= w_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (accept) begin
			seen_q <= seen_next;
		end
	end

	// cell row: cell i holds the minimum of the newest i+1 items
	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		if (i == 0) begin : g_head
			mwm_cell #(.LANES(LIM)) u_cell (
				.clk      (clk),
				.en       (accept),
				.hash_new (hash_in),
				.min_prev (hash_in),
				.min_q    (cell_min[i])
			);
		end else begin : g_body
			mwm_cell #(.LANES(LIM)) u_cell (
				.clk      (clk),
				.en       (accept),
				.hash_new (hash_in),
				.min_prev (cell_min[i-1]),
				.min_q    (cell_min[i])
			);
		end
	end

	// window result: newest item against the prefix minimum one shorter
	assign w_m2  = w_eff - CW'(2);
	assign w_idx = w_m2[IW-1:0];

	always_comb begin
		sel_min = (w_eff == CW'(1)) ? hash_in : cell_min[w_idx];
		for (int l = 0; l < LIM; l++) begin
			win_min[l] = (hash_in[l] < sel_min[l]) ? hash_in[l] : sel_min[l];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= emit;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	for (genvar j = 0; j < PORT_LANES; j++) begin : g_res
		if (j < LIM) begin : g_used
			always_ff @(posedge clk) begin
				if (accept) begin
					out_q[j] <= (LANE_REG_W'(j) < lanes_eff) ? win_min[j] : '0;
				end
			end
		end else begin : g_unused
			always_ff @(posedge clk) begin
				if (accept) begin
					out_q[j] <= '0;
				end
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/mwm_cell.sv @@
`default_nettype none
module mwm_cell #(
	parameter int LANES = 4
) (
	input  wire logic                        clk,
	input  wire logic                        en,
	input  wire mwm_pkg::hash_t [LANES-1:0]  hash_new,
	input  wire mwm_pkg::hash_t [LANES-1:0]  min_prev,
	output      mwm_pkg::hash_t [LANES-1:0]  min_q
);
	import mwm_pkg::*;

	// min of the newest item and the neighbor's prefix minimum, one depth deeper
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < LANES; l++) begin
				min_q[l] <= (hash_new[l] < min_prev[l]) ? hash_new[l] : min_prev[l];
			end
		end
	end

endmodule
`default_nettype wire
